// ===== rtl/core/tzg_pkg.sv =====
// Shared constants and types of the trace zone grouper.
package tzg_pkg;

  // Parameter defaults
  localparam int STACK_DEPTH_DEF = 64;
  localparam int TIME_BITS_DEF   = 48;

  // Fixed field widths
  localparam int LOC_W   = 16;
  localparam int THR_W   = 8;
  localparam int CPU_W   = 6;
  localparam int TYPE_W  = 2;
  localparam int IDX_W   = 32;
  localparam int LEVEL_W = 6;
  localparam int CNT_W   = 32;
  localparam int MODE_W  = 2;
  localparam int REG_W   = 3;

  // Input item modes
  localparam logic [MODE_W-1:0] MODE_SCOPE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_END   = 2'd2;

  // Configuration register indexes
  localparam logic [REG_W-1:0] REG_VIEW_BEGIN = 3'd0;
  localparam logic [REG_W-1:0] REG_VIEW_END   = 3'd1;
  localparam logic [REG_W-1:0] REG_MIN_GROUP  = 3'd2;
  localparam logic [REG_W-1:0] REG_MIN_ZONE   = 3'd3;
  localparam logic [REG_W-1:0] REG_MAX_GAP    = 3'd4;
  localparam logic [REG_W-1:0] REG_MAX_LEVEL  = 3'd5;
  localparam logic [REG_W-1:0] REG_THREAD_SEL = 3'd6;

  // Stack control from the top level
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } tzg_stack_ctrl_t;

endpackage

// ===== rtl/core/tzg_if.sv =====
// Input and result channel interfaces of the trace zone grouper.
interface tzg_in_if #(
  parameter int TIME_BITS = tzg_pkg::TIME_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic [tzg_pkg::MODE_W-1:0]  mode;
  logic                        enter;
  logic [TIME_BITS-1:0]        event_time;
  logic [tzg_pkg::LOC_W-1:0]   location;
  logic [tzg_pkg::THR_W-1:0]   thread;
  logic [tzg_pkg::CPU_W-1:0]   cpu;
  logic [tzg_pkg::TYPE_W-1:0]  zone_type;
  logic [tzg_pkg::IDX_W-1:0]   stream_pos;

  modport source (output valid, mode, enter, event_time, location, thread, cpu, zone_type,
                  stream_pos, input ready);
  modport sink (input valid, mode, enter, event_time, location, thread, cpu, zone_type,
                stream_pos, output ready);
endinterface

interface tzg_out_if #(
  parameter int TIME_BITS = tzg_pkg::TIME_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic [TIME_BITS-1:0]        group_begin;
  logic [TIME_BITS-1:0]        group_end;
  logic [tzg_pkg::LOC_W-1:0]   group_location;
  logic [tzg_pkg::THR_W-1:0]   group_thread;
  logic [tzg_pkg::LEVEL_W-1:0] group_level;
  logic [tzg_pkg::TYPE_W-1:0]  group_type;
  logic [tzg_pkg::CPU_W-1:0]   cpu_first;
  logic [tzg_pkg::CPU_W-1:0]   cpu_last;
  logic [tzg_pkg::IDX_W-1:0]   first_event_index;
  logic [tzg_pkg::CNT_W-1:0]   zone_count;

  modport source (output valid, group_begin, group_end, group_location, group_thread,
                  group_level, group_type, cpu_first, cpu_last, first_event_index,
                  zone_count, input ready);
  modport sink (input valid, group_begin, group_end, group_location, group_thread,
                group_level, group_type, cpu_first, cpu_last, first_event_index,
                zone_count, output ready);
endinterface

// ===== rtl/core/tzg_stack.sv =====
// Zone stack: entry memory, fill counter and registered top-of-stack read.
module tzg_stack #(
  parameter int STACK_DEPTH = tzg_pkg::STACK_DEPTH_DEF,
  parameter int ENT_W       = 104
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tzg_pkg::tzg_stack_ctrl_t        ctrl,
  input  logic [ENT_W-1:0]                push_data,
  output logic                            nonempty,
  output logic [$clog2(STACK_DEPTH)-1:0]  top_level,
  output logic [ENT_W-1:0]                top_data
);
  import tzg_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int FW = $clog2(STACK_DEPTH + 1);

  logic [ENT_W-1:0] mem [STACK_DEPTH];
  logic [FW-1:0]    fill_r, fill_nxt;
  logic [ENT_W-1:0] top_r;
  logic             push_ok, pop_ok;
  logic [AW-1:0]    wr_addr, rd_addr;

  assign push_ok  = ctrl.push && (fill_r < FW'(STACK_DEPTH));
  assign pop_ok   = ctrl.pop && (fill_r != '0);
  assign wr_addr  = fill_r[AW-1:0];
  assign nonempty = (fill_r != '0);
  assign top_level = AW'(fill_r - FW'(1));
  assign top_data  = top_r;

  // Fill count update
  always_comb begin
    fill_nxt = fill_r;
    if (ctrl.clear) begin
      fill_nxt = '0;
    end else if (push_ok) begin
      fill_nxt = fill_r + FW'(1);
    end else if (pop_ok) begin
      fill_nxt = fill_r - FW'(1);
    end
  end

  assign rd_addr = AW'(fill_nxt - FW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // Entry write
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_addr] <= push_data;
    end
  end

  // Top entry read for the next fill, with bypass of a same-cycle push
  always_ff @(posedge clk) begin
    if (push_ok && (wr_addr == rd_addr)) begin
      top_r <= push_data;
    end else begin
      top_r <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/tzg_batch.sv =====
// Batch state: merge of tiny zones, group flush test and result register.
module tzg_batch #(
  parameter int TIME_BITS = tzg_pkg::TIME_BITS_DEF,
  parameter int LVL_W     = 6
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic                          zone_vld,
  input  logic                          flush_req,
  input  logic [TIME_BITS-1:0]          zone_begin,
  input  logic [TIME_BITS-1:0]          zone_end,
  input  logic [tzg_pkg::LOC_W-1:0]     zone_loc,
  input  logic [LVL_W-1:0]              zone_level,
  input  logic [tzg_pkg::TYPE_W-1:0]    zone_type,
  input  logic [tzg_pkg::CPU_W-1:0]     zone_cpu0,
  input  logic [tzg_pkg::CPU_W-1:0]     zone_cpu1,
  input  logic [tzg_pkg::IDX_W-1:0]     zone_idx,
  input  logic [TIME_BITS-1:0]          view_begin,
  input  logic [TIME_BITS-1:0]          view_end,
  input  logic [TIME_BITS-1:0]          min_group_ticks,
  input  logic [TIME_BITS-1:0]          min_zone_ticks,
  input  logic [TIME_BITS-1:0]          max_gap_ticks,
  input  logic [tzg_pkg::LEVEL_W-1:0]   max_zone_level,
  input  logic [tzg_pkg::THR_W-1:0]     thread_sel,
  tzg_out_if.source                     out_if
);
  import tzg_pkg::*;

  localparam int CW = (LVL_W > LEVEL_W) ? LVL_W : LEVEL_W;

  logic [TIME_BITS-1:0] batch_begin_r, batch_end_r;
  logic [LOC_W-1:0]     batch_loc_r;
  logic [THR_W-1:0]     batch_thread_r;
  logic [LEVEL_W-1:0]   batch_level_r;
  logic [TYPE_W-1:0]    batch_type_r;
  logic [CPU_W-1:0]     batch_cpu0_r, batch_cpu1_r;
  logic [IDX_W-1:0]     batch_idx_r;
  logic [CNT_W-1:0]     batch_size_r;

  logic [TIME_BITS-1:0] zone_len, gap, grp_len;
  logic [LEVEL_W-1:0]   lvl6;
  logic                 lvl_ok, tiny, near, merge, start, flush_ok, emit;

  logic                 out_valid_r;
  logic [TIME_BITS-1:0] out_begin_r, out_end_r;
  logic [LOC_W-1:0]     out_loc_r;
  logic [THR_W-1:0]     out_thread_r;
  logic [LEVEL_W-1:0]   out_level_r;
  logic [TYPE_W-1:0]    out_type_r;
  logic [CPU_W-1:0]     out_cpu0_r, out_cpu1_r;
  logic [IDX_W-1:0]     out_idx_r;
  logic [CNT_W-1:0]     out_count_r;

  // Zone tests: level limit, tiny duration, gap to batch end
  assign lvl6     = LEVEL_W'(zone_level);
  assign lvl_ok   = CW'(zone_level) <= CW'(max_zone_level);
  assign zone_len = zone_end - zone_begin;
  assign tiny     = (zone_end < zone_begin) || (zone_len < min_zone_ticks);
  assign gap      = zone_begin - batch_end_r;
  assign near     = (zone_begin < batch_end_r) || (gap < max_gap_ticks);

  // Open batch is worth emitting: long enough and meets the view
  assign grp_len  = batch_end_r - batch_begin_r;
  assign flush_ok = (batch_size_r != '0)
                 && !((batch_end_r < batch_begin_r) || (grp_len < min_group_ticks))
                 && (batch_begin_r <= view_end) && (batch_end_r >= view_begin);

  assign merge = zone_vld && lvl_ok && (batch_size_r != '0) && tiny
              && (zone_loc == batch_loc_r) && (lvl6 == batch_level_r) && near;
  assign start = zone_vld && lvl_ok && !merge;
  assign emit  = (start || flush_req) && flush_ok;

  // Batch count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      batch_size_r <= '0;
    end else if (flush_req) begin
      batch_size_r <= '0;
    end else if (start) begin
      batch_size_r <= CNT_W'(1);
    end else if (merge && (batch_size_r != '1)) begin
      batch_size_r <= batch_size_r + CNT_W'(1);
    end
  end

  // Batch payload
  always_ff @(posedge clk) begin
    if (start) begin
      batch_begin_r  <= zone_begin;
      batch_end_r    <= zone_end;
      batch_loc_r    <= zone_loc;
      batch_thread_r <= thread_sel;
      batch_level_r  <= lvl6;
      batch_type_r   <= zone_type;
      batch_cpu0_r   <= zone_cpu0;
      batch_cpu1_r   <= zone_cpu1;
      batch_idx_r    <= zone_idx;
    end else if (merge) begin
      if (zone_begin < batch_begin_r) begin
        batch_begin_r <= zone_begin;
      end
      if (zone_end > batch_end_r) begin
        batch_end_r <= zone_end;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= emit;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_begin_r  <= batch_begin_r;
      out_end_r    <= batch_end_r;
      out_loc_r    <= batch_loc_r;
      out_thread_r <= batch_thread_r;
      out_level_r  <= batch_level_r;
      out_type_r   <= batch_type_r;
      out_cpu0_r   <= batch_cpu0_r;
      out_cpu1_r   <= batch_cpu1_r;
      out_idx_r    <= batch_idx_r;
      out_count_r  <= batch_size_r;
    end
  end

  assign out_if.valid             = out_valid_r;
  assign out_if.group_begin       = out_begin_r;
  assign out_if.group_end         = out_end_r;
  assign out_if.group_location    = out_loc_r;
  assign out_if.group_thread      = out_thread_r;
  assign out_if.group_level       = out_level_r;
  assign out_if.group_type        = out_type_r;
  assign out_if.cpu_first         = out_cpu0_r;
  assign out_if.cpu_last          = out_cpu1_r;
  assign out_if.first_event_index = out_idx_r;
  assign out_if.zone_count        = out_count_r;

endmodule

// ===== rtl/core/trace_zone_grouper.sv =====
// Top level of the trace zone grouper: configuration, input register and stage control.
//
// Usage: trace events enter on in_if (valid/ready); a transaction is accepted at a rising
// edge with valid and ready high. Scope events of the selected thread push on enter and
// pop on leave; a popped zone within the level limit either merges into the open batch
// or flushes it. Closed groups leave on out_if (valid/ready), at most one per input
// transaction. Clear and end items act on every thread.
// Order: an accepted transaction waits in the input register until out_if is free, and
// its group, if any, is then registered into the result register that drives out_if.
// Throughput: one transaction per cycle unless out_if stalls; the stack top is read from a
// registered memory port addressed with the next fill count; back-to-back pops need no bubble.
// Stall: while a result waits on out_if, the input register holds its transaction and
// in_if.ready drops only when both are occupied.
// Reset (rst_n, synchronous, active low): the stack and the batch are empty, no result is
// pending, and the configuration takes its reset values. No clearing pass is needed.
// Configuration: cfg_we writes cfg_data to register cfg_index; the user writes only while idle (unchecked).
module trace_zone_grouper #(
  parameter int STACK_DEPTH = tzg_pkg::STACK_DEPTH_DEF,
  parameter int TIME_BITS   = tzg_pkg::TIME_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  tzg_in_if.sink                       in_if,
  tzg_out_if.source                    out_if,
  input  logic                         cfg_we,
  input  logic [tzg_pkg::REG_W-1:0]    cfg_index,
  input  logic [TIME_BITS-1:0]         cfg_data
);
  import tzg_pkg::*;

  localparam int AW    = $clog2(STACK_DEPTH);
  localparam int ENT_W = TIME_BITS + LOC_W + IDX_W + CPU_W + TYPE_W;

  // Configuration registers
  logic [TIME_BITS-1:0] view_begin_r, view_end_r, min_group_r, min_zone_r, max_gap_r;
  logic [LEVEL_W-1:0]   max_level_r;
  logic [THR_W-1:0]     thread_sel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_begin_r <= '0;
      view_end_r   <= '1;
      min_group_r  <= '0;
      min_zone_r   <= '0;
      max_gap_r    <= '0;
      max_level_r  <= '1;
      thread_sel_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VIEW_BEGIN: view_begin_r <= cfg_data;
        REG_VIEW_END:   view_end_r   <= cfg_data;
        REG_MIN_GROUP:  min_group_r  <= cfg_data;
        REG_MIN_ZONE:   min_zone_r   <= cfg_data;
        REG_MAX_GAP:    max_gap_r    <= cfg_data;
        REG_MAX_LEVEL:  max_level_r  <= cfg_data[LEVEL_W-1:0];
        REG_THREAD_SEL: thread_sel_r <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register and stage control
  logic                 in_vld_r;
  logic [MODE_W-1:0]    in_mode_r;
  logic                 in_enter_r;
  logic [TIME_BITS-1:0] in_time_r;
  logic [LOC_W-1:0]     in_loc_r;
  logic [THR_W-1:0]     in_thread_r;
  logic [CPU_W-1:0]     in_cpu_r;
  logic [TYPE_W-1:0]    in_type_r;
  logic [IDX_W-1:0]     in_idx_r;
  logic                 out_free, step, take;

  assign out_free    = !out_if.valid || out_if.ready;
  assign step        = in_vld_r && out_free;
  assign in_if.ready = !in_vld_r || out_free;
  assign take        = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (take) begin
      in_vld_r <= 1'b1;
    end else if (step) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_mode_r   <= in_if.mode;
      in_enter_r  <= in_if.enter;
      in_time_r   <= in_if.event_time;
      in_loc_r    <= in_if.location;
      in_thread_r <= in_if.thread;
      in_cpu_r    <= in_if.cpu;
      in_type_r   <= in_if.zone_type;
      in_idx_r    <= in_if.stream_pos;
    end
  end

  // Decode of the item in the input register
  tzg_stack_ctrl_t  stk_ctrl;
  logic             scope_ok, stk_nonempty, zone_vld, flush_req;
  logic [AW-1:0]    top_level;
  logic [ENT_W-1:0] push_data, top_data;

  assign scope_ok       = step && (in_mode_r == MODE_SCOPE) && (in_thread_r == thread_sel_r);
  assign stk_ctrl.push  = scope_ok && in_enter_r;
  assign stk_ctrl.pop   = scope_ok && !in_enter_r;
  assign stk_ctrl.clear = step && ((in_mode_r == MODE_CLEAR) || (in_mode_r == MODE_END));
  assign flush_req      = step && (in_mode_r == MODE_END);
  assign zone_vld       = stk_ctrl.pop && stk_nonempty;
  assign push_data      = {in_type_r, in_cpu_r, in_idx_r, in_loc_r, in_time_r};

  tzg_stack #(
    .STACK_DEPTH (STACK_DEPTH),
    .ENT_W       (ENT_W)
  ) u_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (stk_ctrl),
    .push_data (push_data),
    .nonempty  (stk_nonempty),
    .top_level (top_level),
    .top_data  (top_data)
  );

  tzg_batch #(
    .TIME_BITS (TIME_BITS),
    .LVL_W     (AW)
  ) u_batch (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (step),
    .zone_vld        (zone_vld),
    .flush_req       (flush_req),
    .zone_begin      (top_data[TIME_BITS-1:0]),
    .zone_end        (in_time_r),
    .zone_loc        (top_data[TIME_BITS+LOC_W-1:TIME_BITS]),
    .zone_level      (top_level),
    .zone_type       (top_data[ENT_W-1:ENT_W-TYPE_W]),
    .zone_cpu0       (top_data[ENT_W-TYPE_W-1:ENT_W-TYPE_W-CPU_W]),
    .zone_cpu1       (in_cpu_r),
    .zone_idx        (top_data[TIME_BITS+LOC_W+IDX_W-1:TIME_BITS+LOC_W]),
    .view_begin      (view_begin_r),
    .view_end        (view_end_r),
    .min_group_ticks (min_group_r),
    .min_zone_ticks  (min_zone_r),
    .max_gap_ticks   (max_gap_r),
    .max_zone_level  (max_level_r),
    .thread_sel      (thread_sel_r),
    .out_if          (out_if)
  );

endmodule

// ===== tb/tb_trace_zone_grouper.sv =====
// Self-checking testbench of the trace zone grouper: directed and random trace streams against an in-line model.
module tb_trace_zone_grouper;
  import tzg_pkg::*;

  localparam int TW          = TIME_BITS_DEF;
  localparam int DEPTH       = STACK_DEPTH_DEF;
  localparam int STK_AW      = $clog2(DEPTH);
  localparam logic [TW-1:0] TMAX = '1;
  localparam int STALL_LIMIT = 2000;   // cycles without any transaction
  localparam int HOLD_CYCLES = 400;    // long receiver hold-off
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;  // unused mode, must be a no-op

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              enter;
    logic [TW-1:0]     t;
    logic [LOC_W-1:0]  loc;
    logic [THR_W-1:0]  thr;
    logic [CPU_W-1:0]  cpu;
    logic [TYPE_W-1:0] ztype;
    logic [IDX_W-1:0]  idx;
  } trace_ev_t;

  typedef struct packed {
    logic [TW-1:0]      gbegin;
    logic [TW-1:0]      gend;
    logic [LOC_W-1:0]   loc;
    logic [THR_W-1:0]   thr;
    logic [LEVEL_W-1:0] level;
    logic [TYPE_W-1:0]  gtype;
    logic [CPU_W-1:0]   cpu0;
    logic [CPU_W-1:0]   cpu1;
    logic [IDX_W-1:0]   first_idx;
    logic [CNT_W-1:0]   count;
  } zone_group_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [REG_W-1:0]  cfg_index;
  logic [TW-1:0]     cfg_data;

  tzg_in_if  #(.TIME_BITS(TW)) in_ch ();
  tzg_out_if #(.TIME_BITS(TW)) out_ch ();

  trace_zone_grouper #(.STACK_DEPTH(DEPTH), .TIME_BITS(TW)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // Model copy of the configuration
  logic [TW-1:0]      cf_view_begin, cf_view_end, cf_min_group, cf_min_zone, cf_max_gap;
  logic [LEVEL_W-1:0] cf_max_level;
  logic [THR_W-1:0]   cf_thread;

  // Model zone stack and open batch (count zero: no batch open)
  logic [TW-1:0]     stk_begin [DEPTH];
  logic [LOC_W-1:0]  stk_loc   [DEPTH];
  logic [IDX_W-1:0]  stk_idx   [DEPTH];
  logic [TYPE_W-1:0] stk_type  [DEPTH];
  logic [CPU_W-1:0]  stk_cpu   [DEPTH];
  int                stk_fill;
  zone_group_t       batch;

  trace_ev_t   trace_queue[$];
  zone_group_t expected_groups[$];
  trace_ev_t   cur_ev;

  // Stimulus generator state
  logic [TW-1:0]    gen_t;
  logic [LOC_W-1:0] loc_pool [4];
  logic [LOC_W-1:0] open_locs[$];

  int n_queued = 0, n_accepted = 0, n_groups = 0, n_merged = 0, n_errors = 0;
  int settings_used = 0, peak_fill = 0, full_drops = 0, deep_drops = 0;
  int src_idle_pct = 0, snk_idle_pct = 0, src_gap = 0, snk_gap = 0;
  int hold_left = 0, quiet_cycles = 0;
  bit hold_request = 1'b0;
  bit ev_taken = 1'b0;

  // ---------------------------------------------------------------- model

  // true when end - begin is negative or below the limit
  function automatic bit below(input logic [TW-1:0] b, input logic [TW-1:0] e,
                               input logic [TW-1:0] lim);
    return (e < b) || ((e - b) < lim);
  endfunction

  function automatic void flush_batch();
    if (batch.count != 0 && !below(batch.gbegin, batch.gend, cf_min_group) &&
        batch.gbegin <= cf_view_end && batch.gend >= cf_view_begin)
      expected_groups.push_back(batch);
  endfunction

  function automatic void close_zone(input int lvl, input logic [CPU_W-1:0] cpu_leave,
                                     input logic [TW-1:0] t_leave);
    logic [TW-1:0] zb;
    bit            fits;
    zb = stk_begin[STK_AW'(lvl)];
    if (lvl > int'(cf_max_level)) begin
      deep_drops++;
      return;
    end
    fits = batch.count != 0 && below(zb, t_leave, cf_min_zone) &&
           batch.loc == stk_loc[STK_AW'(lvl)] && batch.level == LEVEL_W'(lvl);
    // negative gap counts as near
    if (fits && (zb < batch.gend || (zb - batch.gend) < cf_max_gap)) begin
      if (zb < batch.gbegin) batch.gbegin = zb;
      if (t_leave > batch.gend) batch.gend = t_leave;
      if (batch.count != '1) batch.count++;
      return;
    end
    flush_batch();
    batch.gbegin    = zb;
    batch.gend      = t_leave;
    batch.loc       = stk_loc[STK_AW'(lvl)];
    batch.thr       = cf_thread;
    batch.level     = LEVEL_W'(lvl);
    batch.gtype     = stk_type[STK_AW'(lvl)];
    batch.cpu0      = stk_cpu[STK_AW'(lvl)];
    batch.cpu1      = cpu_leave;
    batch.first_idx = stk_idx[STK_AW'(lvl)];
    batch.count     = 1;
  endfunction

  function automatic void predict_groups(input trace_ev_t ev);
    case (ev.mode)
      MODE_CLEAR: stk_fill = 0;
      MODE_END: begin
        flush_batch();
        batch.count = '0;
        stk_fill = 0;
      end
      MODE_SCOPE: begin
        if (ev.thr == cf_thread) begin
          if (ev.enter) begin
            if (stk_fill >= DEPTH) begin
              full_drops++;
            end else begin
              stk_begin[STK_AW'(stk_fill)] = ev.t;
              stk_loc[STK_AW'(stk_fill)]   = ev.loc;
              stk_idx[STK_AW'(stk_fill)]   = ev.idx;
              stk_type[STK_AW'(stk_fill)]  = ev.ztype;
              stk_cpu[STK_AW'(stk_fill)]   = ev.cpu;
              stk_fill++;
              if (stk_fill > peak_fill) peak_fill = stk_fill;
            end
          end else if (stk_fill > 0) begin
            stk_fill--;
            close_zone(stk_fill, ev.cpu, ev.t);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [9:0] field_diffs(input zone_group_t a, input zone_group_t b);
    return {a.gbegin !== b.gbegin, a.gend !== b.gend, a.loc !== b.loc, a.thr !== b.thr,
            a.level !== b.level, a.gtype !== b.gtype, a.cpu0 !== b.cpu0,
            a.cpu1 !== b.cpu1, a.first_idx !== b.first_idx, a.count !== b.count};
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic logic [TW-1:0] rand_ticks();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[TW-1:0];
  endfunction

  function automatic logic [LOC_W-1:0] pick_loc();
    if ($urandom_range(0, 99) < 85) return loc_pool[2'($urandom_range(0, 3))];
    return LOC_W'($urandom);
  endfunction

  task automatic push_ev(input logic [MODE_W-1:0] m, input logic ent, input logic [TW-1:0] t,
                         input logic [LOC_W-1:0] loc, input logic [THR_W-1:0] thr,
                         input logic [CPU_W-1:0] cpu, input logic [TYPE_W-1:0] ztype,
                         input logic [IDX_W-1:0] idx);
    trace_ev_t ev;
    ev = '{mode: m, enter: ent, t: t, loc: loc, thr: thr, cpu: cpu, ztype: ztype, idx: idx};
    trace_queue.push_back(ev);
    n_queued++;
  endtask

  // scope event of the selected thread on the running timeline
  task automatic gen_scope(input logic ent, input logic [LOC_W-1:0] loc);
    int r;
    r = $urandom_range(0, 99);
    if (r < 2)      gen_t = rand_ticks();
    else if (r < 5) gen_t = gen_t - TW'($urandom_range(0, 40));   // time goes backward
    else            gen_t = gen_t + TW'($urandom_range(0, 12));
    push_ev(MODE_SCOPE, ent, gen_t, loc, cf_thread, CPU_W'($urandom), TYPE_W'($urandom),
            $urandom);
  endtask

  // nest depth levels deep, past the stack depth when depth exceeds DEPTH, then unwind
  task automatic dive_trace(input int depth);
    repeat (depth) gen_scope(1'b1, pick_loc());
    repeat (depth) gen_scope(1'b0, pick_loc());
  endtask

  task automatic gen_trace(input int n_items);
    int               made, r, k;
    logic [THR_W-1:0] thr;
    logic [LOC_W-1:0] loc;
    made = 0;
    while (made < n_items) begin
      r = $urandom_range(0, 999);
      if (r < 50) begin
        // random-thread noise, fully random fields (may hit the selected thread)
        thr = THR_W'($urandom);
        push_ev(MODE_SCOPE, 1'($urandom), rand_ticks(), LOC_W'($urandom), thr,
                CPU_W'($urandom), TYPE_W'($urandom), $urandom);
        if (thr == cf_thread) made++;
      end else if (r < 70) begin
        push_ev(MODE_CLEAR, 1'($urandom), rand_ticks(), LOC_W'($urandom), THR_W'($urandom),
                CPU_W'($urandom), TYPE_W'($urandom), $urandom);
        open_locs.delete();
        made++;
      end else if (r < 85) begin
        push_ev(MODE_END, 1'($urandom), rand_ticks(), LOC_W'($urandom), THR_W'($urandom),
                CPU_W'($urandom), TYPE_W'($urandom), $urandom);
        open_locs.delete();
        made++;
      end else if (r < 95) begin
        push_ev(MODE_SPARE, 1'($urandom), rand_ticks(), LOC_W'($urandom), cf_thread,
                CPU_W'($urandom), TYPE_W'($urandom), $urandom);
      end else if (r < 97) begin
        k = $urandom_range(60, 68);
        dive_trace(k);
        made += 2 * k;
      end else if (r < 400 && open_locs.size() < 12) begin
        loc = pick_loc();
        gen_scope(1'b1, loc);
        open_locs.push_back(loc);
        made++;
      end else if (r < 700) begin
        gen_scope(1'b0, LOC_W'($urandom));
        if (open_locs.size() > 0) void'(open_locs.pop_back());
        made++;
      end else begin
        // run of short zones at one location and level
        loc = pick_loc();
        k = $urandom_range(1, 8);
        repeat (k) begin
          gen_scope(1'b1, loc);
          gen_scope(1'b0, LOC_W'($urandom));
        end
        made += 2 * k;
      end
    end
  endtask

  // register write; the model copy follows at once since the block is idle
  task automatic write_reg(input logic [REG_W-1:0] idx, input logic [TW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_VIEW_BEGIN: cf_view_begin = val;
      REG_VIEW_END:   cf_view_end   = val;
      REG_MIN_GROUP:  cf_min_group  = val;
      REG_MIN_ZONE:   cf_min_zone   = val;
      REG_MAX_GAP:    cf_max_gap    = val;
      REG_MAX_LEVEL:  cf_max_level  = val[LEVEL_W-1:0];
      REG_THREAD_SEL: cf_thread     = val[THR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [TW-1:0] vb, input logic [TW-1:0] ve,
                          input logic [TW-1:0] min_grp, input logic [TW-1:0] min_zn,
                          input logic [TW-1:0] gap, input logic [TW-1:0] lvl,
                          input logic [TW-1:0] thr);
    write_reg(REG_VIEW_BEGIN, vb);
    write_reg(REG_VIEW_END, ve);
    write_reg(REG_MIN_GROUP, min_grp);
    write_reg(REG_MIN_ZONE, min_zn);
    write_reg(REG_MAX_GAP, gap);
    write_reg(REG_MAX_LEVEL, lvl);
    write_reg(REG_THREAD_SEL, thr);
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // queue a phase and wait until every transaction and group has gone through
  task automatic run_phase(input int n_items, input int src_pct, input int snk_pct);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    loc_pool[2] = LOC_W'($urandom);
    loc_pool[3] = LOC_W'($urandom);
    gen_trace(n_items);
    while (n_accepted != n_queued || expected_groups.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- driver

  always @(negedge clk) begin : send_events
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || ev_taken) begin
      ev_taken = 1'b0;
      if (src_gap > 0) begin
        src_gap--;
        in_ch.valid <= 1'b0;
      end else if (trace_queue.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else if ($urandom_range(0, 99) < src_idle_pct) begin
        src_gap = $urandom_range(0, 18);
        in_ch.valid <= 1'b0;
      end else begin
        cur_ev = trace_queue.pop_front();
        in_ch.mode        <= cur_ev.mode;
        in_ch.enter       <= cur_ev.enter;
        in_ch.event_time  <= cur_ev.t;
        in_ch.location    <= cur_ev.loc;
        in_ch.thread      <= cur_ev.thr;
        in_ch.cpu         <= cur_ev.cpu;
        in_ch.zone_type   <= cur_ev.ztype;
        in_ch.stream_pos  <= cur_ev.idx;
        in_ch.valid       <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  always @(negedge clk) begin : accept_groups
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        out_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < snk_idle_pct) begin
        snk_gap = $urandom_range(0, 18);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- prediction, check, watchdog

  always @(posedge clk) begin : score
    zone_group_t got, want;
    logic [9:0]  diffs;
    bit          moved;
    moved = 1'b0;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      predict_groups(cur_ev);
      ev_taken = 1'b1;
      n_accepted++;
      moved = 1'b1;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      moved = 1'b1;
      got = {out_ch.group_begin, out_ch.group_end, out_ch.group_location, out_ch.group_thread,
             out_ch.group_level, out_ch.group_type, out_ch.cpu_first, out_ch.cpu_last,
             out_ch.first_event_index, out_ch.zone_count};
      n_groups++;
      if (got.count > 1) n_merged++;
      if (expected_groups.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("unexpected group: begin=%h end=%h loc=%h cnt=%0d",
                   got.gbegin, got.gend, got.loc, got.count);
      end else begin
        want = expected_groups.pop_front();
        diffs = field_diffs(want, got);
        if (diffs != 0) begin
          n_errors++;
          if (n_errors <= 10) begin
            $display("group %0d mismatch, fields %b", n_groups, diffs);
            $display("  exp begin=%h end=%h loc=%h thr=%h lvl=%0d typ=%0d cpu=%0d/%0d idx=%h cnt=%0d",
                     want.gbegin, want.gend, want.loc, want.thr, want.level, want.gtype,
                     want.cpu0, want.cpu1, want.first_idx, want.count);
            $display("  got begin=%h end=%h loc=%h thr=%h lvl=%0d typ=%0d cpu=%0d/%0d idx=%h cnt=%0d",
                     got.gbegin, got.gend, got.loc, got.thr, got.level, got.gtype,
                     got.cpu0, got.cpu1, got.first_idx, got.count);
          end
        end
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d groups outstanding",
               quiet_cycles, expected_groups.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.mode        = MODE_SCOPE;
    in_ch.enter       = 1'b0;
    in_ch.event_time  = '0;
    in_ch.location    = '0;
    in_ch.thread      = '0;
    in_ch.cpu         = '0;
    in_ch.zone_type   = '0;
    in_ch.stream_pos  = '0;
    out_ch.ready      = 1'b0;

    // model reset state
    cf_view_begin = '0;
    cf_view_end   = TMAX;
    cf_min_group  = '0;
    cf_min_zone   = '0;
    cf_max_gap    = '0;
    cf_max_level  = '1;
    cf_thread     = '0;
    stk_fill      = 0;
    batch         = '0;
    gen_t         = '0;
    loc_pool[0]   = '0;
    loc_pool[1]   = '1;
    loc_pool[2]   = LOC_W'($urandom);
    loc_pool[3]   = LOC_W'($urandom);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part on reset settings (thread 0, nothing tiny, no gap)
    src_idle_pct = 3;
    snk_idle_pct = 3;
    push_ev(MODE_SCOPE, 1'b1, '0, '0, '0, '0, '0, '0);
    push_ev(MODE_SCOPE, 1'b0, '0, '1, '0, '1, '1, '1);
    push_ev(MODE_SCOPE, 1'b1, TMAX, '1, '0, '1, '1, '1);
    push_ev(MODE_SCOPE, 1'b0, 48'd5, '0, '0, '0, '0, '0);         // leave before enter
    push_ev(MODE_SCOPE, 1'b1, 48'd100, 16'd7, 8'd1, 6'd3, 2'd1, 32'd9);  // foreign thread
    push_ev(MODE_SCOPE, 1'b0, 48'd100, 16'd7, '1, 6'd3, 2'd1, 32'd9);
    push_ev(MODE_SCOPE, 1'b0, 48'd200, '0, '0, 6'd5, 2'd2, 32'd11);  // empty stack
    push_ev(MODE_SPARE, 1'b1, 48'd50, '0, '0, 6'd1, 2'd1, 32'd12);
    push_ev(MODE_SCOPE, 1'b1, 48'd3, '1, '0, 6'd17, 2'd2, 32'h8000_0000);
    push_ev(MODE_SCOPE, 1'b0, 48'd1, '0, '0, 6'd33, 2'd0, 32'd13);   // merges, negative gap
    push_ev(MODE_SCOPE, 1'b1, 48'd100, 16'd7, '0, 6'd2, 2'd3, 32'd14);
    push_ev(MODE_SCOPE, 1'b1, 48'd101, 16'd8, '0, 6'd4, 2'd1, 32'd15);
    push_ev(MODE_CLEAR, 1'b1, '1, '1, '1, '1, '1, '1);
    push_ev(MODE_SCOPE, 1'b0, 48'd102, '0, '0, 6'd6, 2'd0, 32'd16);
    push_ev(MODE_END, 1'b0, '0, '0, '1, '0, '0, '0);
    push_ev(MODE_END, 1'b1, '1, '1, '0, '1, '1, '1);               // nothing open
    push_ev(MODE_SCOPE, 1'b1, 48'd200, 16'd1, '0, 6'd7, 2'd2, 32'd20);
    push_ev(MODE_SCOPE, 1'b1, 48'd201, 16'd2, '0, 6'd8, 2'd3, 32'd21);
    push_ev(MODE_SCOPE, 1'b0, 48'd250, '0, '0, 6'd9, 2'd0, 32'd22);
    push_ev(MODE_SCOPE, 1'b0, 48'd300, '0, '0, 6'd10, 2'd0, 32'd23);
    push_ev(MODE_END, 1'b0, 48'd301, '0, 8'd42, '0, '0, 32'd24);
    while (n_accepted != n_queued || expected_groups.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    // common merge settings, with a stack overflow up front
    set_regs('0, TMAX, '0, 48'd16, 48'd24, 48'd63, 48'd5);
    gen_t = 48'd1000;
    dive_trace(66);
    run_phase(400, 3, 3);

    // narrow view, level cap, long receiver hold-off
    set_regs(48'd10200, 48'd13000, 48'd20, 48'd40, 48'd8, 48'd7, 48'd200);
    gen_t = 48'd10000;
    hold_request = 1'b1;
    run_phase(400, 3, 0);

    // everything tiny and near, only the outer level kept
    set_regs('0, TMAX, '0, TMAX, TMAX, '0, 48'd255);
    run_phase(300, 0, 4);

    // timeline wrapping through the top of the tick range
    set_regs(48'd1, TMAX - TW'(1), 48'd1, 48'd1, 48'd1, 48'd62, '0);
    gen_t = TMAX - TW'(2000);
    run_phase(300, 4, 2);

    // closing stretch at full rate
    set_regs('0, TMAX, '0, 48'd12, 48'd30, 48'd63, 48'd17);
    run_phase(320, 0, 0);
    repeat (10) @(posedge clk);

    $display("covered %0d trace transactions under %0d register settings; %0d groups checked,",
             n_accepted, settings_used + 1, n_groups);
    $display("%0d merged, stack depth up to %0d, %0d full-stack and %0d too-deep drops",
             n_merged, peak_fill, full_drops, deep_drops);
    if (n_errors == 0 && expected_groups.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d groups never seen", n_errors, expected_groups.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/tzg_pkg.sv
rtl/core/tzg_if.sv
rtl/core/tzg_stack.sv
rtl/core/tzg_batch.sv
rtl/core/trace_zone_grouper.sv
tb/tb_trace_zone_grouper.sv
